### sv/rau_pkg.sv
`timescale 1ns / 1ps

package rau_pkg;

  // internal arithmetic width; operands wrap to this many bits
  localparam int DATA_WIDTH = 32;
  localparam int FIELD_W    = 32;
  localparam int ALU_W      = DATA_WIDTH + 1;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [ALU_W-1:0]      alu_word_t;
  typedef logic [FIELD_W-1:0]    field_t;

  typedef enum logic [1:0] {
    KIND_ADD,
    KIND_SUB,
    KIND_MUL,
    KIND_DIV
  } rau_kind_t;

  typedef struct packed {
    logic start;
    logic take;
  } rau_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } rau_sts_t;

  // sign-extend a 32-bit field, then wrap to the internal width
  function automatic word_t from_field(input field_t f);
    logic [FIELD_W+63:0] ext;
    ext = {{64{f[FIELD_W-1]}}, f};
    return ext[DATA_WIDTH-1:0];
  endfunction

  // sign-extend from the internal width, then keep 32 bits
  function automatic field_t to_field(input word_t v);
    logic [DATA_WIDTH+FIELD_W-1:0] ext;
    ext = {{FIELD_W{v[DATA_WIDTH-1]}}, v};
    return ext[FIELD_W-1:0];
  endfunction

endpackage

### sv/rau_alu.sv
`timescale 1ns / 1ps

module rau_alu (
  input  rau_pkg::alu_word_t op_a,
  input  rau_pkg::alu_word_t op_b,
  input  logic               op_sub,
  output rau_pkg::alu_word_t sum,
  output logic               ge
);

  logic [rau_pkg::ALU_W:0] full;
  rau_pkg::alu_word_t      b_x;

  assign b_x  = op_sub ? ~op_b : op_b;
  assign full = {1'b0, op_a} + {1'b0, b_x} + {{rau_pkg::ALU_W{1'b0}}, op_sub};
  assign sum  = full[rau_pkg::ALU_W-1:0];
  // carry out of a subtract: op_a >= op_b, unsigned
  assign ge   = full[rau_pkg::ALU_W];

endmodule

### sv/rau_core.sv
`timescale 1ns / 1ps

module rau_core (
  input  logic               clk,
  input  logic               rst_n,
  input  rau_pkg::rau_ctl_t  ctl,
  input  logic [1:0]         in_kind,
  input  rau_pkg::field_t    in_left_num,
  input  rau_pkg::field_t    in_left_den,
  input  rau_pkg::field_t    in_right_num,
  input  rau_pkg::field_t    in_right_den,
  output rau_pkg::rau_sts_t  sts,
  output rau_pkg::field_t    res_num,
  output rau_pkg::field_t    res_den
);

  localparam int W = rau_pkg::DATA_WIDTH;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADDSUB,
    ST_CHECK,
    ST_ABS_NUM,
    ST_ABS_DEN,
    ST_GCD_STEP,
    ST_ALIGN,
    ST_REDUCE,
    ST_DIV_END,
    ST_SIGN_NUM,
    ST_SIGN_DEN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MS_NUM,
    MS_DEN,
    MS_CROSS
  } mul_sel_t;

  typedef enum logic [1:0] {
    DS_GCD,
    DS_QNUM,
    DS_QDEN
  } div_sel_t;

  state_t              state_r, state_nxt;
  rau_pkg::rau_kind_t  kind_r, kind_nxt;
  rau_pkg::word_t      ld_r, ld_nxt;
  rau_pkg::word_t      rn_r, rn_nxt;
  rau_pkg::word_t      rd_r, rd_nxt;
  rau_pkg::word_t      num_r, num_nxt;
  rau_pkg::word_t      den_r, den_nxt;
  rau_pkg::word_t      acc_r, acc_nxt;
  rau_pkg::word_t      mc_r, mc_nxt;
  rau_pkg::word_t      mp_r, mp_nxt;
  mul_sel_t            mul_sel_r, mul_sel_nxt;
  rau_pkg::word_t      mag_num_r, mag_num_nxt;
  rau_pkg::word_t      mag_den_r, mag_den_nxt;
  rau_pkg::word_t      ga_r, ga_nxt;
  rau_pkg::word_t      gb_r, gb_nxt;
  rau_pkg::word_t      rem_r, rem_nxt;
  rau_pkg::alu_word_t  dv_r, dv_nxt;
  rau_pkg::word_t      div_r, div_nxt;
  rau_pkg::word_t      q_r, q_nxt;
  div_sel_t            div_sel_r, div_sel_nxt;
  logic                par_r, par_nxt;
  rau_pkg::word_t      res_num_r, res_num_nxt;
  rau_pkg::word_t      res_den_r, res_den_nxt;

  rau_pkg::alu_word_t  alu_a, alu_b, alu_sum;
  logic                alu_sub, alu_ge;

  rau_pkg::word_t      ln_in, ld_in, rn_in, rd_in;
  rau_pkg::rau_kind_t  kind_in;
  logic                num_neg, den_neg, g_neg;

  rau_alu u_alu (
    .op_a   (alu_a),
    .op_b   (alu_b),
    .op_sub (alu_sub),
    .sum    (alu_sum),
    .ge     (alu_ge)
  );

  assign kind_in = rau_pkg::rau_kind_t'(in_kind);
  assign ln_in   = rau_pkg::from_field(in_left_num);
  assign rn_in   = rau_pkg::from_field(in_right_num);
  // zero denominators count as one
  assign ld_in   = (rau_pkg::from_field(in_left_den) == '0) ?
                   rau_pkg::word_t'(1) : rau_pkg::from_field(in_left_den);
  assign rd_in   = (rau_pkg::from_field(in_right_den) == '0) ?
                   rau_pkg::word_t'(1) : rau_pkg::from_field(in_right_den);

  assign num_neg = num_r[W-1];
  assign den_neg = den_r[W-1];
  // truncating remainders keep the dividend sign, so the gcd sign follows
  // whichever of num/den started its chain
  assign g_neg   = par_r ? den_neg : num_neg;

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    ld_nxt      = ld_r;
    rn_nxt      = rn_r;
    rd_nxt      = rd_r;
    num_nxt     = num_r;
    den_nxt     = den_r;
    acc_nxt     = acc_r;
    mc_nxt      = mc_r;
    mp_nxt      = mp_r;
    mul_sel_nxt = mul_sel_r;
    mag_num_nxt = mag_num_r;
    mag_den_nxt = mag_den_r;
    ga_nxt      = ga_r;
    gb_nxt      = gb_r;
    rem_nxt     = rem_r;
    dv_nxt      = dv_r;
    div_nxt     = div_r;
    q_nxt       = q_r;
    div_sel_nxt = div_sel_r;
    par_nxt     = par_r;
    res_num_nxt = res_num_r;
    res_den_nxt = res_den_r;
    alu_a       = '0;
    alu_b       = '0;
    alu_sub     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (ctl.start) begin
          kind_nxt    = kind_in;
          ld_nxt      = ld_in;
          rn_nxt      = rn_in;
          rd_nxt      = rd_in;
          acc_nxt     = '0;
          mc_nxt      = ln_in;
          mp_nxt      = (kind_in == rau_pkg::KIND_MUL) ? rn_in : rd_in;
          mul_sel_nxt = MS_NUM;
          state_nxt   = ST_MUL;
        end
      end

      ST_MUL: begin
        alu_a = {1'b0, acc_r};
        alu_b = {1'b0, mc_r};
        if (mp_r == '0) begin
          case (mul_sel_r)
            MS_NUM: begin
              num_nxt     = acc_r;
              acc_nxt     = '0;
              mc_nxt      = ld_r;
              mp_nxt      = (kind_r == rau_pkg::KIND_DIV) ? rn_r : rd_r;
              mul_sel_nxt = MS_DEN;
            end
            MS_DEN: begin
              den_nxt = acc_r;
              if (kind_r inside {rau_pkg::KIND_ADD, rau_pkg::KIND_SUB}) begin
                acc_nxt     = '0;
                mc_nxt      = rn_r;
                mp_nxt      = ld_r;
                mul_sel_nxt = MS_CROSS;
              end else begin
                state_nxt = ST_CHECK;
              end
            end
            default: begin
              state_nxt = ST_ADDSUB;
            end
          endcase
        end else begin
          // shift-add, stops once the multiplier runs out of ones
          if (mp_r[0]) begin
            acc_nxt = alu_sum[W-1:0];
          end
          mc_nxt = {mc_r[W-2:0], 1'b0};
          mp_nxt = {1'b0, mp_r[W-1:1]};
        end
      end

      ST_ADDSUB: begin
        alu_a     = {1'b0, num_r};
        alu_b     = {1'b0, acc_r};
        alu_sub   = (kind_r == rau_pkg::KIND_SUB);
        num_nxt   = alu_sum[W-1:0];
        state_nxt = ST_CHECK;
      end

      ST_CHECK: begin
        if (num_r == '0 || den_r == '0) begin
          res_num_nxt = num_r;
          res_den_nxt = den_r;
          state_nxt   = ST_DONE;
        end else begin
          state_nxt = ST_ABS_NUM;
        end
      end

      ST_ABS_NUM: begin
        alu_b       = {1'b0, num_r};
        alu_sub     = 1'b1;
        mag_num_nxt = num_neg ? alu_sum[W-1:0] : num_r;
        ga_nxt      = mag_num_nxt;
        state_nxt   = ST_ABS_DEN;
      end

      ST_ABS_DEN: begin
        alu_b       = {1'b0, den_r};
        alu_sub     = 1'b1;
        mag_den_nxt = den_neg ? alu_sum[W-1:0] : den_r;
        gb_nxt      = mag_den_nxt;
        par_nxt     = 1'b0;
        state_nxt   = ST_GCD_STEP;
      end

      ST_GCD_STEP: begin
        q_nxt     = '0;
        state_nxt = ST_ALIGN;
        if (gb_r == '0) begin
          rem_nxt     = mag_num_r;
          div_nxt     = ga_r;
          dv_nxt      = {1'b0, ga_r};
          div_sel_nxt = DS_QNUM;
        end else begin
          rem_nxt     = ga_r;
          div_nxt     = gb_r;
          dv_nxt      = {1'b0, gb_r};
          div_sel_nxt = DS_GCD;
        end
      end

      ST_ALIGN: begin
        // double the divisor while it still fits under the remainder
        alu_a   = {1'b0, rem_r};
        alu_b   = {dv_r[W-1:0], 1'b0};
        alu_sub = 1'b1;
        if (alu_ge) begin
          dv_nxt = {dv_r[W-1:0], 1'b0};
        end else begin
          state_nxt = ST_REDUCE;
        end
      end

      ST_REDUCE: begin
        alu_a   = {1'b0, rem_r};
        alu_b   = dv_r;
        alu_sub = 1'b1;
        if (alu_ge) begin
          rem_nxt = alu_sum[W-1:0];
        end
        q_nxt = {q_r[W-2:0], alu_ge};
        if (dv_r == {1'b0, div_r}) begin
          state_nxt = ST_DIV_END;
        end else begin
          dv_nxt = {1'b0, dv_r[W:1]};
        end
      end

      ST_DIV_END: begin
        case (div_sel_r)
          DS_GCD: begin
            ga_nxt    = gb_r;
            gb_nxt    = rem_r;
            par_nxt   = ~par_r;
            state_nxt = ST_GCD_STEP;
          end
          DS_QNUM: begin
            res_num_nxt = q_r;
            rem_nxt     = mag_den_r;
            dv_nxt      = {1'b0, ga_r};
            q_nxt       = '0;
            div_sel_nxt = DS_QDEN;
            state_nxt   = ST_ALIGN;
          end
          default: begin
            res_den_nxt = q_r;
            state_nxt   = ST_SIGN_NUM;
          end
        endcase
      end

      ST_SIGN_NUM: begin
        alu_b   = {1'b0, res_num_r};
        alu_sub = 1'b1;
        if (num_neg ^ g_neg) begin
          res_num_nxt = alu_sum[W-1:0];
        end
        state_nxt = ST_SIGN_DEN;
      end

      ST_SIGN_DEN: begin
        alu_b   = {1'b0, res_den_r};
        alu_sub = 1'b1;
        if (den_neg ^ g_neg) begin
          res_den_nxt = alu_sum[W-1:0];
        end
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (ctl.take) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    kind_r    <= kind_nxt;
    ld_r      <= ld_nxt;
    rn_r      <= rn_nxt;
    rd_r      <= rd_nxt;
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    acc_r     <= acc_nxt;
    mc_r      <= mc_nxt;
    mp_r      <= mp_nxt;
    mul_sel_r <= mul_sel_nxt;
    mag_num_r <= mag_num_nxt;
    mag_den_r <= mag_den_nxt;
    ga_r      <= ga_nxt;
    gb_r      <= gb_nxt;
    rem_r     <= rem_nxt;
    dv_r      <= dv_nxt;
    div_r     <= div_nxt;
    q_r       <= q_nxt;
    div_sel_r <= div_sel_nxt;
    par_r     <= par_nxt;
    res_num_r <= res_num_nxt;
    res_den_r <= res_den_nxt;
  end

  assign sts.idle = (state_r == ST_IDLE);
  assign sts.done = (state_r == ST_DONE);
  assign res_num  = rau_pkg::to_field(res_num_r);
  assign res_den  = rau_pkg::to_field(res_den_r);

endmodule

### sv/rational_arith_unit.sv
`timescale 1ns / 1ps

// rational_arith_unit: add, subtract, multiply or divide two signed fractions
// and reduce the result by a truncating-remainder Euclidean gcd.
// input channel: in_valid/in_ready carry one beat of in_kind and the two
// operands (num/den pairs); a zero operand denominator is read as one.
// output channel: out_valid/out_ready carry one beat of out_res_num and
// out_res_den per input beat, in order. a zero raw numerator or denominator
// passes unreduced, so division by zero gives out_res_den == 0.
// one item at a time: in_ready is high only while the core is idle. all
// arithmetic goes through one add/subtract/compare unit under a sequencer:
// each product is shift-add, one multiplier bit per cycle (two products,
// three for add and subtract); each remainder step aligns the divisor and
// then reduces one quotient bit at a time; the two final exact divisions
// work the same way. the time an item takes is data dependent; the result
// then goes into the output register, and sits there; the core can take
// the next beat while that register waits on out_ready, but it holds its
// own finished result until the register frees up.
// reset (rst_n low, synchronous) drops any item in flight and clears
// out_valid.

module rational_arith_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_left_num,
  input  logic [31:0] in_left_den,
  input  logic [31:0] in_right_num,
  input  logic [31:0] in_right_den,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_res_num,
  output logic [31:0] out_res_den
);

  rau_pkg::rau_ctl_t ctl;
  rau_pkg::rau_sts_t sts;
  rau_pkg::field_t   core_num, core_den;

  logic              out_valid_r;
  rau_pkg::field_t   out_num_r, out_den_r;

  rau_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .in_kind      (in_kind),
    .in_left_num  (in_left_num),
    .in_left_den  (in_left_den),
    .in_right_num (in_right_num),
    .in_right_den (in_right_den),
    .sts          (sts),
    .res_num      (core_num),
    .res_den      (core_den)
  );

  assign in_ready  = sts.idle;
  assign ctl.start = in_valid && sts.idle;
  // move the finished result once the output slot is empty or draining
  assign ctl.take  = sts.done && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (ctl.take) begin
      out_num_r <= core_num;
      out_den_r <= core_den;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_res_num = out_num_r;
  assign out_res_den = out_den_r;

endmodule

### sv/rau_checker.sv
`timescale 1ns / 1ps

module rau_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_res_num,
  input logic [31:0] out_res_den
);

  logic [1:0] pend_r;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // items taken in but not yet handed out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_beat} - {1'b0, out_beat};
    end
  end

  // one item at a time in the core
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !in_ready)
    else $error("in_ready high right after an input beat");

  // the core is released as the result moves to the output register
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("new result without the core going idle");

  // no result without a matching input beat, at most two in flight
  a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid |-> pend_r != 2'd0) and (pend_r != 2'd3))
    else $error("result count does not match input beats");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res_num) && $stable(out_res_den))
    else $error("stalled result changed or dropped");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (.*);
